// ===== design/cffe_pkg.sv =====
// cffe_pkg: shared types and constants of the clipped frame store fill engine
// used by cffe_front, cffe_queue, cffe_back and the top level; no dependencies
package cffe_pkg;

  // default frame store dimensions
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // clipped coordinates never exceed the 7-bit frame size registers
  localparam int COORD_W = 7;
  localparam int PIX_W   = 16;
  localparam int CMD_W   = 3;

  // jobs held between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [COORD_W-1:0]   FRAME_SIZE_RST   = 7'd64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PIXEL = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HLINE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_VLINE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RECT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FILL  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [PIX_W-1:0] x_pos;
    logic signed [PIX_W-1:0] y_pos;
    logic signed [PIX_W-1:0] span_width;
    logic signed [PIX_W-1:0] span_height;
    logic [PIX_W-1:0]        color;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             read_in_range;
  } out_item_t;

  // what the back end has to do with a job
  typedef enum logic [1:0] {
    OP_NONE,
    OP_FILL,
    OP_READ
  } cffe_op_t;

  // clipped job: columns [x0, x1), rows [y0, y1); reads use x0, y0
  typedef struct packed {
    cffe_op_t           op;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [PIX_W-1:0]   color;
  } cffe_job_t;

endpackage

// ===== design/cffe_front.sv =====
// cffe_front: frame size registers, command decode and clipping into jobs
// depends on cffe_pkg
module cffe_front #(
  parameter int MAX_WIDTH  = cffe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cffe_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cffe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cffe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cffe_pkg::in_item_t               in_data,
  input  logic                             clear_busy,
  input  logic                             q_full,
  output logic                             q_push,
  output cffe_pkg::cffe_job_t              q_job,
  output logic [cffe_pkg::COORD_W-1:0]     eff_w
);
  import cffe_pkg::*;

  localparam int SW = PIX_W + 2;

  logic [COORD_W-1:0]   fw_r, fh_r;
  logic [COORD_W-1:0]   eff_h;
  logic signed [SW-1:0] xs, ys, sws, shs, ws, hs;
  logic signed [SW-1:0] bx0, bx1, by0, by1;
  logic signed [SW-1:0] cx0, cx1, cy0, cy1;
  logic                 draw, box_ok, rd_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_SIZE_RST;
      fh_r <= FRAME_SIZE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= cfg_data;
        REG_FRAME_HEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame size saturates at the store dimensions
  assign eff_w = (int'(fw_r) > MAX_WIDTH)  ? COORD_W'(MAX_WIDTH)  : fw_r;
  assign eff_h = (int'(fh_r) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : fh_r;

  assign xs  = {{2{in_data.x_pos[PIX_W-1]}}, in_data.x_pos};
  assign ys  = {{2{in_data.y_pos[PIX_W-1]}}, in_data.y_pos};
  assign sws = {{2{in_data.span_width[PIX_W-1]}}, in_data.span_width};
  assign shs = {{2{in_data.span_height[PIX_W-1]}}, in_data.span_height};
  assign ws  = {{(SW-COORD_W){1'b0}}, eff_w};
  assign hs  = {{(SW-COORD_W){1'b0}}, eff_h};

  // unclipped box per command
  always_comb begin
    bx0  = xs;
    bx1  = xs + SW'(1);
    by0  = ys;
    by1  = ys + SW'(1);
    draw = 1'b0;
    case (in_data.command)
      CMD_PIXEL: draw = 1'b1;
      CMD_HLINE: begin
        bx1  = xs + sws;
        draw = !sws[SW-1] && (sws != '0);
      end
      CMD_VLINE: begin
        by1  = ys + shs;
        draw = !shs[SW-1] && (shs != '0);
      end
      CMD_RECT: begin
        // negative size: start moves back, end stays one past the origin
        if (sws[SW-1]) begin
          bx0 = xs + sws + SW'(1);
        end else begin
          bx1 = xs + sws;
        end
        if (shs[SW-1]) begin
          by0 = ys + shs + SW'(1);
        end else begin
          by1 = ys + shs;
        end
        draw = (sws != '0) && (shs != '0);
      end
      CMD_FILL: begin
        bx0  = '0;
        bx1  = ws;
        by0  = '0;
        by1  = hs;
        draw = 1'b1;
      end
      default: draw = 1'b0;
    endcase
  end

  // clip to the frame
  assign cx0    = bx0[SW-1] ? '0 : bx0;
  assign cy0    = by0[SW-1] ? '0 : by0;
  assign cx1    = (bx1 > ws) ? ws : bx1;
  assign cy1    = (by1 > hs) ? hs : by1;
  assign box_ok = (cx0 < cx1) && (cy0 < cy1);

  assign rd_ok = (in_data.command == CMD_READ) && !xs[SW-1] && (xs < ws)
                 && !ys[SW-1] && (ys < hs);

  always_comb begin
    q_job.color = in_data.color;
    q_job.x0    = cx0[COORD_W-1:0];
    q_job.x1    = cx1[COORD_W-1:0];
    q_job.y0    = cy0[COORD_W-1:0];
    q_job.y1    = cy1[COORD_W-1:0];
    q_job.op    = OP_NONE;
    if (draw && box_ok) begin
      q_job.op = OP_FILL;
    end else if (rd_ok) begin
      q_job.op = OP_READ;
      q_job.x0 = xs[COORD_W-1:0];
      q_job.y0 = ys[COORD_W-1:0];
    end
  end

  assign in_ready = !clear_busy && !q_full;
  assign q_push   = in_valid && in_ready;

endmodule

// ===== design/cffe_queue.sv =====
// cffe_queue: short job queue between front and back
// depends on cffe_pkg
module cffe_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cffe_pkg::cffe_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output cffe_pkg::cffe_job_t head_job
);
  import cffe_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cffe_job_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [PW:0]     cnt_r;
  logic            do_push, do_pop;

  assign full       = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/cffe_back.sv =====
// cffe_back: frame store, clearing pass, fill walker, reads and result register
// depends on cffe_pkg
module cffe_back #(
  parameter int MAX_WIDTH  = cffe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cffe_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cffe_pkg::COORD_W-1:0] eff_w,
  input  logic                         q_valid,
  input  cffe_pkg::cffe_job_t          q_job,
  output logic                         q_pop,
  output logic                         clear_busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cffe_pkg::out_item_t          out_data
);
  import cffe_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AXW   = ((AW > COORD_W) ? AW : COORD_W) + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BASE,
    S_FILL,
    S_READ,
    S_RDATA
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        clr_r;
  cffe_op_t             op_r;
  logic [COORD_W-1:0]   cx_r, cy_r, x0_r, x1_r, y1_r;
  logic [PIX_W-1:0]     color_r;
  logic [AXW-1:0]       base_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [PIX_W-1:0]     mem [DEPTH];
  logic [PIX_W-1:0]     rdata_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [PIX_W-1:0]     mem_wdata;

  logic [2*COORD_W-1:0] row_prod;
  logic [AXW-1:0]       pix_addr;
  logic [COORD_W:0]     cx_inc, cy_inc;
  logic                 slot_free, last_col, last_row;

  assign slot_free  = !out_valid_r || out_ready;
  assign q_pop      = (state_r == S_IDLE) && q_valid && slot_free;
  assign clear_busy = (state_r == S_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign row_prod = cy_r * eff_w;
  assign pix_addr = base_r + AXW'(cx_r);
  assign cx_inc   = {1'b0, cx_r} + 1'b1;
  assign cy_inc   = {1'b0, cy_r} + 1'b1;
  assign last_col = (cx_inc == {1'b0, x1_r});
  assign last_row = (cy_inc == {1'b0, y1_r});

  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_FILL);
  assign mem_addr  = (state_r == S_CLEAR) ? clr_r : pix_addr[AW-1:0];
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : color_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH-1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            op_r    <= q_job.op;
            cx_r    <= q_job.x0;
            x0_r    <= q_job.x0;
            x1_r    <= q_job.x1;
            cy_r    <= q_job.y0;
            y1_r    <= q_job.y1;
            color_r <= q_job.color;
            if (q_job.op == OP_NONE) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '0;
            end else begin
              state_r <= S_BASE;
            end
          end
        end
        S_BASE: begin
          base_r  <= AXW'(row_prod);
          state_r <= (op_r == OP_READ) ? S_READ : S_FILL;
        end
        S_FILL: begin
          if (last_col) begin
            cx_r   <= x0_r;
            cy_r   <= cy_inc[COORD_W-1:0];
            base_r <= base_r + AXW'(eff_w);
            if (last_row) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '0;
              state_r     <= S_IDLE;
            end
          end else begin
            cx_r <= cx_inc[COORD_W-1:0];
          end
        end
        S_READ: state_r <= S_RDATA;
        S_RDATA: begin
          out_valid_r                <= 1'b1;
          out_data_r.pixel_value     <= rdata_r;
          out_data_r.read_in_range   <= 1'b1;
          state_r                    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/clipped_framebuffer_fill_engine_unit.sv =====
// clipped_framebuffer_fill_engine_unit: 16-bit frame store with clipped fills
// a job passes the queue, then the back end; a no-op or out-of-range read sets
// the result register on its pop, a fill goes S_BASE then S_FILL, a read goes
// S_BASE, S_READ, S_RDATA; one result register, the store has one port
// the fill walker writes one pixel a cycle; a job is popped only in S_IDLE with
// a free result slot; reset (rst_n low, synchronous) sets frame size 64 x 64 and
// clears MAX_WIDTH * MAX_HEIGHT words (4096 by default); no item taken until done
module clipped_framebuffer_fill_engine_unit #(
  parameter int MAX_WIDTH  = cffe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cffe_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes, always ready
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cffe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cffe_pkg::CFG_DATA_W-1:0] cfg_data,
  // command items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cffe_pkg::in_item_t              in_data,
  // one result item per command
  output logic                            out_valid,
  input  logic                            out_ready,
  output cffe_pkg::out_item_t             out_data
);
  import cffe_pkg::*;

  // front to queue
  logic               q_push, q_full;
  cffe_job_t          push_job;
  // queue to back
  logic               q_pop, q_valid;
  cffe_job_t          head_job;
  // shared frame pitch and clearing status
  logic [COORD_W-1:0] eff_w;
  logic               clear_busy;

  // front: frame size registers, decode, normalize and clip each command
  cffe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job),
    .eff_w      (eff_w)
  );

  // decouples command decode from the pixel walker
  cffe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  // back: store, clearing pass, fill walker, reads, result register
  cffe_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_w      (eff_w),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // no command enters while the store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !in_ready)
    else $error("item accepted during clearing pass");

  // the queue never takes a job while full
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("job pushed into full queue");

  // results that are not in-range reads carry a zero pixel
  a_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.read_in_range) |-> (out_data.pixel_value == '0))
    else $error("nonzero pixel on a result without a read");

  // a job is only taken when the queue holds one
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

endmodule
